@@ rtl/nfsa_pkg.sv @@
// Shared types and constants of the nearest free slot allocator.
`timescale 1ns / 1ps

package nfsa_pkg;

    localparam int CFG_W  = 4;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [4:0] DIST_SAT = 5'd31;

    typedef enum logic [IDX_W-1:0] {
        CFG_ENT_ROW     = 2'd0,
        CFG_ENT_COL     = 2'd1,
        CFG_SMALL_LAST  = 2'd2,
        CFG_MEDIUM_LAST = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_SMALL   = 2'd0,
        CLS_MEDIUM  = 2'd1,
        CLS_LARGE   = 2'd2,
        CLS_INVALID = 2'd3
    } t_size_class;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_READ,
        ST_WR_MOD,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] ent_row;
        logic [CFG_W-1:0] ent_col;
        logic [CFG_W-1:0] small_last;
        logic [CFG_W-1:0] medium_last;
    } t_cfg;

    typedef struct packed {
        logic [4:0]  pad;
        t_size_class size_class;
        logic        occupied_value;
        logic [3:0]  cell_col;
        logic [3:0]  cell_row;
    } t_in_word;

    typedef struct packed {
        logic [1:0] pad;
        logic [4:0] distance;
        logic [3:0] spot_col;
        logic [3:0] spot_row;
        logic       found;
    } t_out_word;

endpackage

@@ rtl/nearest_free_slot_allocator_core.sv @@
// Top level of the nearest free slot allocator: control, best-cell tracking and result register.
//
//  Channel | Direction | Handshake               | Contents
//  s       | in        | i_s_tvalid / o_s_tready | one write or allocate word
//  m       | out       | o_m_tvalid / i_m_tready | one result word per allocate
//  cfg     | in        | i_cfg_wr_en             | entrance and class column limits
//
// A write word passes through accept, row read and row write-back, in that order.
// An allocate word reads one grid row per cycle, then drains the row search and commits;
// an allocate word with an invalid class goes straight from accept to commit.
// After reset every cell is free at once; rows carry valid bits, so no clearing pass is needed.
// A result waits in the output register while the next word is accepted; the block
// only holds in its final step when a new result finds that register still full.
`timescale 1ns / 1ps

module nearest_free_slot_allocator_core
    import nfsa_pkg::*;
#(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // cell_row[3:0], cell_col[7:4], occupied_value[8], size_class[10:9], zero[15:11]
    input  logic [DATA_W-1:0] i_s_tdata,
    // operation[0]
    input  logic              i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // found[0], spot_row[4:1], spot_col[8:5], distance[13:9], zero[15:14]
    output logic [DATA_W-1:0] o_m_tdata,
    input  logic              i_cfg_wr_en,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int RW   = $clog2(GRID_ROWS);
    localparam int CW   = $clog2(GRID_COLS);
    localparam int RMAX = (GRID_ROWS-1 > 15) ? GRID_ROWS-1 : 15;
    localparam int CMAX = (GRID_COLS-1 > 15) ? GRID_COLS-1 : 15;
    localparam int DW   = $clog2(RMAX+CMAX+1);

    t_state               r_state;
    t_state               n_state;
    t_cfg                 r_cfg;
    t_in_word             r_item;
    logic [RW-1:0]        r_scan_row;
    logic                 r_rd_pend;
    logic [RW-1:0]        r_rd_row;
    logic                 r_best_hit;
    logic [RW-1:0]        r_best_row;
    logic [CW-1:0]        r_best_col;
    logic [GRID_COLS-1:0] r_best_word;
    logic [DW-1:0]        r_best_dist;
    logic                 r_out_vld;
    t_out_word            r_out_word;

    t_in_word             w_in;
    logic                 w_accept;
    logic                 w_in_range;
    logic                 w_out_free;
    logic                 w_scan_last;
    logic                 w_rd_en;
    logic                 w_scan_rd;
    logic [RW-1:0]        w_rd_addr;
    logic [GRID_COLS-1:0] w_rd_data;
    logic                 w_wr_en;
    logic [RW-1:0]        w_wr_addr;
    logic [GRID_COLS-1:0] w_wr_data;
    logic [GRID_COLS-1:0] w_mod_word;
    logic [GRID_COLS-1:0] w_set_word;
    logic                 w_out_load;
    t_out_word            w_out_word;
    logic                 w_rm_vld;
    logic                 w_rm_hit;
    logic [RW-1:0]        w_rm_row;
    logic [CW-1:0]        w_rm_col;
    logic [GRID_COLS-1:0] w_rm_word;
    logic [DW-1:0]        w_rm_dist;
    logic                 w_best_upd;

    assign w_in        = t_in_word'(i_s_tdata);
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_in_range  = (int'(w_in.cell_row) < GRID_ROWS) && (int'(w_in.cell_col) < GRID_COLS);
    assign w_out_free  = !r_out_vld || i_m_tready;
    assign w_scan_last = (r_scan_row == RW'(GRID_ROWS-1));
    assign w_best_upd  = w_rm_vld && w_rm_hit && (!r_best_hit || (w_rm_dist < r_best_dist));

    nfsa_grid_mem #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_grid_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    nfsa_row_min #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_row_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_pend),
        .i_row   (r_rd_row),
        .i_word  (w_rd_data),
        .i_cfg   (r_cfg),
        .i_cls   (r_item.size_class),
        .o_vld   (w_rm_vld),
        .o_hit   (w_rm_hit),
        .o_row   (w_rm_row),
        .o_col   (w_rm_col),
        .o_word  (w_rm_word),
        .o_dist  (w_rm_dist)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == OP_WRITE) begin
                        n_state = w_in_range ? ST_WR_READ : ST_IDLE;
                    end else if (w_in.size_class == CLS_INVALID) begin
                        n_state = ST_COMMIT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_WR_READ: n_state = ST_WR_MOD;
            ST_WR_MOD:  n_state = ST_IDLE;
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_pend && !w_rm_vld) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_mod_word                        = w_rd_data;
        w_mod_word[CW'(r_item.cell_col)]  = r_item.occupied_value;
        w_set_word                        = r_best_word;
        w_set_word[r_best_col]            = 1'b1;
        w_out_word                        = '0;
        if (r_best_hit) begin
            w_out_word.found    = 1'b1;
            w_out_word.spot_row = 4'(r_best_row);
            w_out_word.spot_col = 4'(r_best_col);
            w_out_word.distance = (r_best_dist > DW'(DIST_SAT)) ? DIST_SAT : 5'(r_best_dist);
        end
    end

    always_comb begin
        w_rd_en    = 1'b0;
        w_scan_rd  = 1'b0;
        w_rd_addr  = r_scan_row;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_best_row;
        w_wr_data  = w_set_word;
        w_out_load = 1'b0;
        case (r_state)
            ST_WR_READ: begin
                w_rd_en   = 1'b1;
                w_rd_addr = RW'(r_item.cell_row);
            end
            ST_WR_MOD: begin
                w_wr_en   = 1'b1;
                w_wr_addr = RW'(r_item.cell_row);
                w_wr_data = w_mod_word;
            end
            ST_SCAN: begin
                w_rd_en   = 1'b1;
                w_scan_rd = 1'b1;
            end
            ST_COMMIT: begin
                w_out_load = w_out_free;
                w_wr_en    = w_out_free && r_best_hit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= ST_IDLE;
            r_cfg.ent_row       <= 4'd0;
            r_cfg.ent_col       <= 4'd0;
            r_cfg.small_last    <= 4'd5;
            r_cfg.medium_last   <= 4'd11;
            r_scan_row          <= '0;
            r_rd_pend           <= 1'b0;
            r_best_hit          <= 1'b0;
            r_out_vld           <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= w_scan_rd;
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ENT_ROW:     r_cfg.ent_row     <= i_cfg_data;
                    CFG_ENT_COL:     r_cfg.ent_col     <= i_cfg_data;
                    CFG_SMALL_LAST:  r_cfg.small_last  <= i_cfg_data;
                    CFG_MEDIUM_LAST: r_cfg.medium_last <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_scan_row <= '0;
            end else if (w_scan_rd) begin
                r_scan_row <= r_scan_row + 1'b1;
            end
            if (w_accept) begin
                r_best_hit <= 1'b0;
            end else if (w_best_upd) begin
                r_best_hit <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_in;
        end
        if (w_scan_rd) begin
            r_rd_row <= r_scan_row;
        end
        if (w_best_upd) begin
            r_best_row  <= w_rm_row;
            r_best_col  <= w_rm_col;
            r_best_word <= w_rm_word;
            r_best_dist <= w_rm_dist;
        end
        if (w_out_load) begin
            r_out_word <= w_out_word;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = DATA_W'(r_out_word);

`ifndef ASSERT_OFF
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !w_wr_en)
        else $error("grid written during a row scan");

    a_commit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |-> (!r_rd_pend && !w_rm_vld))
        else $error("result committed with row reads still in flight");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_out_word.found) |->
        (r_out_word.spot_row == 4'd0 && r_out_word.spot_col == 4'd0
         && r_out_word.distance == 5'd0))
        else $error("not-found word carries nonzero fields");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_m_tvalid)
        else $error("loaded result word not presented");
`endif

endmodule

@@ rtl/nfsa_grid_mem.sv @@
// Occupancy memory: one word per grid row, registered read, per-row valid bits.
`timescale 1ns / 1ps

module nfsa_grid_mem
    import nfsa_pkg::*;
#(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(GRID_ROWS)-1:0] i_rd_addr,
    output logic [GRID_COLS-1:0]         o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(GRID_ROWS)-1:0] i_wr_addr,
    input  logic [GRID_COLS-1:0]         i_wr_data
);

    logic [GRID_COLS-1:0] r_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] r_row_vld;
    logic [GRID_COLS-1:0] r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_row_vld[i_rd_addr];
        end
    end

    // A row never written since reset reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ rtl/nfsa_row_min.sv @@
// Per-row search for the nearest free cell of the requested class, registered.
`timescale 1ns / 1ps

module nfsa_row_min
    import nfsa_pkg::*;
#(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [$clog2(GRID_ROWS)-1:0] i_row,
    input  logic [GRID_COLS-1:0]         i_word,
    input  t_cfg                         i_cfg,
    input  t_size_class                  i_cls,
    output logic                         o_vld,
    output logic                         o_hit,
    output logic [$clog2(GRID_ROWS)-1:0] o_row,
    output logic [$clog2(GRID_COLS)-1:0] o_col,
    output logic [GRID_COLS-1:0]         o_word,
    output logic [$clog2(((GRID_ROWS-1 > 15) ? GRID_ROWS-1 : 15)
                         + ((GRID_COLS-1 > 15) ? GRID_COLS-1 : 15) + 1)-1:0] o_dist
);

    localparam int RW   = $clog2(GRID_ROWS);
    localparam int CW   = $clog2(GRID_COLS);
    localparam int RMAX = (GRID_ROWS-1 > 15) ? GRID_ROWS-1 : 15;
    localparam int CMAX = (GRID_COLS-1 > 15) ? GRID_COLS-1 : 15;
    localparam int RXW  = $clog2(RMAX+1);
    localparam int CXW  = $clog2(CMAX+1);
    localparam int DW   = $clog2(RMAX+CMAX+1);

    t_size_class          w_col_cls [GRID_COLS];
    logic [GRID_COLS-1:0] w_cand;
    logic                 w_left_hit;
    logic                 w_right_hit;
    logic [CW-1:0]        w_left_col;
    logic [CW-1:0]        w_right_col;
    logic [CXW-1:0]       w_ec;
    logic [CXW-1:0]       w_left_d;
    logic [CXW-1:0]       w_right_d;
    logic                 w_take_left;
    logic [CXW-1:0]       w_col_d;
    logic [RXW-1:0]       w_r;
    logic [RXW-1:0]       w_er;
    logic [RXW-1:0]       w_row_d;
    logic                 w_hit;
    logic [CW-1:0]        w_col;
    logic [DW-1:0]        w_dist;

    logic                 r_vld;
    logic                 r_hit;
    logic [RW-1:0]        r_row;
    logic [CW-1:0]        r_col;
    logic [GRID_COLS-1:0] r_word;
    logic [DW-1:0]        r_dist;

    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            if (CXW'(c) <= CXW'(i_cfg.small_last)) begin
                w_col_cls[c] = CLS_SMALL;
            end else if (CXW'(c) <= CXW'(i_cfg.medium_last)) begin
                w_col_cls[c] = CLS_MEDIUM;
            end else begin
                w_col_cls[c] = CLS_LARGE;
            end
            w_cand[c] = !i_word[c] && (w_col_cls[c] == i_cls);
        end
    end

    // Nearest candidate at or left of the entrance column, and at or right of it.
    always_comb begin
        w_ec        = CXW'(i_cfg.ent_col);
        w_left_hit  = 1'b0;
        w_left_col  = '0;
        w_right_hit = 1'b0;
        w_right_col = '0;
        for (int c = 0; c < GRID_COLS; c++) begin
            if (w_cand[c] && (CXW'(c) <= w_ec)) begin
                w_left_hit = 1'b1;
                w_left_col = CW'(c);
            end
        end
        for (int c = GRID_COLS-1; c >= 0; c--) begin
            if (w_cand[c] && (CXW'(c) >= w_ec)) begin
                w_right_hit = 1'b1;
                w_right_col = CW'(c);
            end
        end
    end

    always_comb begin
        w_left_d    = w_ec - CXW'(w_left_col);
        w_right_d   = CXW'(w_right_col) - w_ec;
        w_take_left = w_left_hit && (!w_right_hit || (w_left_d <= w_right_d));
        w_col       = w_take_left ? w_left_col : w_right_col;
        w_col_d     = w_take_left ? w_left_d : w_right_d;
        w_hit       = w_left_hit || w_right_hit;
        w_r         = RXW'(i_row);
        w_er        = RXW'(i_cfg.ent_row);
        w_row_d     = (w_r >= w_er) ? (w_r - w_er) : (w_er - w_r);
        w_dist      = DW'(w_row_d) + DW'(w_col_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_hit  <= w_hit;
            r_row  <= i_row;
            r_col  <= w_col;
            r_word <= i_word;
            r_dist <= w_dist;
        end
    end

    assign o_vld  = r_vld;
    assign o_hit  = r_hit;
    assign o_row  = r_row;
    assign o_col  = r_col;
    assign o_word = r_word;
    assign o_dist = r_dist;

endmodule
